// ===== hdl/pssm_pkg.sv =====
// Shared types, codes and constants of the power scene state machine.
`timescale 1ns / 1ps
`default_nettype none

package pssm_pkg;

	localparam logic [3:0] MODE_COUNT = 4'd4;
	localparam logic [2:0] MODE_RESET = 3'd1;
	localparam logic [15:0] SLACK_RESET = 16'd3000;
	localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
	localparam logic [15:0] COOLDOWN_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		SC_IDLE    = 3'd0,
		SC_TOUCH   = 3'd1,
		SC_TRIGGER = 3'd2,
		SC_GESTURE = 3'd3,
		SC_JUNK    = 3'd4,
		SC_SWITCH  = 3'd5,
		SC_BOOST   = 3'd6
	} scene_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_EVENT = 2'd1,
		REQ_MODE  = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

	localparam logic [3:0] EV_TOUCH_DOWN    = 4'd0;
	localparam logic [3:0] EV_TOUCH_UP      = 4'd1;
	localparam logic [3:0] EV_SWIPE         = 4'd2;
	localparam logic [3:0] EV_GESTURE       = 4'd3;
	localparam logic [3:0] EV_JUNK          = 4'd4;
	localparam logic [3:0] EV_WINDOW_SWITCH = 4'd5;
	localparam logic [3:0] EV_TIMEOUT       = 4'd6;
	localparam logic [3:0] EV_HEAVY_START   = 4'd7;
	localparam logic [3:0] EV_HEAVY_END     = 4'd8;

	localparam logic [2:0] CFG_HINT_TOUCH   = 3'd0;
	localparam logic [2:0] CFG_HINT_TRIGGER = 3'd1;
	localparam logic [2:0] CFG_HINT_JUNK    = 3'd2;
	localparam logic [2:0] CFG_HINT_GESTURE = 3'd3;
	localparam logic [2:0] CFG_HINT_SWITCH  = 3'd4;
	localparam logic [2:0] CFG_BURST_SLACK  = 3'd5;
	localparam logic [2:0] CFG_HEAVY_THRESH = 3'd6;

	typedef struct packed {
		logic [19:0] hint_touch_ms;
		logic [19:0] hint_trigger_ms;
		logic [19:0] hint_junk_ms;
		logic [19:0] hint_gesture_ms;
		logic [19:0] hint_switch_ms;
		logic [15:0] burst_slack_ms;
		logic [15:0] load_threshold;
	} cfg_t;

	typedef struct packed {
		scene_t      scene;
		logic [2:0]  mode;
		logic [19:0] elapsed;
		logic        heavy;
		logic        boost_exited;
		logic [15:0] cooldown;
	} state_t;

	typedef struct packed {
		req_t        req_type;
		logic [3:0]  event_code;
		logic [2:0]  new_mode;
		logic [15:0] load_level;
	} item_t;

	typedef struct packed {
		logic       boost_needed;
		logic       heavy_active;
		logic       scene_changed;
		logic [2:0] power_mode;
		logic [2:0] scene;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/pssm_step.sv =====
// Next-state and result logic for one request word.
`timescale 1ns / 1ps
`default_nettype none

module pssm_step (
	input  wire pssm_pkg::state_t  state,
	input  wire pssm_pkg::cfg_t    cfg,
	input  wire pssm_pkg::item_t   item,
	output pssm_pkg::state_t       state_next,
	output pssm_pkg::result_t      result
);
	import pssm_pkg::*;

	logic [19:0] elapsed_inc;
	logic [15:0] cooldown_inc;
	logic [19:0] hint;
	scene_t      hint_next;
	scene_t      ev_next;
	scene_t      target;
	logic        boost_needed;

	assign elapsed_inc  = (state.elapsed == ELAPSED_MAX) ? state.elapsed : state.elapsed + 20'd1;
	assign cooldown_inc = (state.cooldown == COOLDOWN_MAX) ? state.cooldown
	                                                       : state.cooldown + 16'd1;

	always_comb begin
		hint      = '0;
		hint_next = SC_TOUCH;
		case (state.scene)
			SC_TOUCH: begin
				hint      = cfg.hint_touch_ms;
				hint_next = SC_IDLE;
			end
			SC_TRIGGER: hint = cfg.hint_trigger_ms;
			SC_JUNK:    hint = cfg.hint_junk_ms;
			SC_GESTURE: hint = cfg.hint_gesture_ms;
			SC_SWITCH:  hint = cfg.hint_switch_ms;
			default:    hint = '0;
		endcase
	end

	// transition table, heavy start handled separately
	always_comb begin
		ev_next = state.scene;
		case (state.scene)
			SC_IDLE: begin
				if (item.event_code == EV_TOUCH_DOWN)
					ev_next = SC_TOUCH;
				else if (item.event_code == EV_WINDOW_SWITCH)
					ev_next = SC_SWITCH;
			end
			SC_TOUCH: begin
				if (item.event_code == EV_TOUCH_UP)
					ev_next = SC_TRIGGER;
				else if (item.event_code == EV_SWIPE || item.event_code == EV_GESTURE)
					ev_next = SC_GESTURE;
				else if (item.event_code == EV_JUNK)
					ev_next = SC_JUNK;
				else if (item.event_code == EV_WINDOW_SWITCH)
					ev_next = SC_SWITCH;
				else if (item.event_code == EV_TIMEOUT)
					ev_next = SC_IDLE;
			end
			SC_TRIGGER, SC_JUNK: begin
				if (item.event_code == EV_TIMEOUT || item.event_code == EV_TOUCH_UP)
					ev_next = SC_TOUCH;
				else if (item.event_code == EV_WINDOW_SWITCH)
					ev_next = SC_SWITCH;
			end
			SC_GESTURE: begin
				if (item.event_code == EV_TIMEOUT)
					ev_next = SC_TOUCH;
				else if (item.event_code == EV_WINDOW_SWITCH)
					ev_next = SC_SWITCH;
			end
			SC_SWITCH: begin
				if (item.event_code == EV_TIMEOUT)
					ev_next = SC_TOUCH;
			end
			SC_BOOST: begin
				if (item.event_code == EV_HEAVY_END)
					ev_next = SC_TOUCH;
				else if (item.event_code == EV_TIMEOUT)
					ev_next = SC_IDLE;
			end
			default: ev_next = state.scene;
		endcase
	end

	always_comb begin
		state_next   = state;
		target       = state.scene;
		boost_needed = 1'b0;
		case (item.req_type)
			REQ_TICK: begin
				state_next.elapsed  = elapsed_inc;
				state_next.cooldown = cooldown_inc;
				if (hint != '0 && elapsed_inc >= hint)
					target = hint_next;
			end
			REQ_EVENT: begin
				if (item.event_code == EV_HEAVY_START) begin
					state_next.heavy = 1'b1;
					target           = SC_BOOST;
				end else begin
					target = ev_next;
					if (state.scene == SC_BOOST && item.event_code == EV_HEAVY_END) begin
						state_next.heavy        = 1'b0;
						state_next.boost_exited = 1'b1;
						state_next.cooldown     = '0;
					end
				end
			end
			REQ_MODE: begin
				if ({1'b0, item.new_mode} < MODE_COUNT && item.new_mode != state.mode) begin
					state_next.mode         = item.new_mode;
					state_next.elapsed      = '0;
					state_next.heavy        = 1'b0;
					state_next.boost_exited = 1'b0;
					state_next.cooldown     = '0;
					target                  = SC_IDLE;
				end
			end
			REQ_QUERY: begin
				if (state.heavy)
					boost_needed = 1'b1;
				else if (state.boost_exited && state.cooldown < cfg.burst_slack_ms)
					boost_needed = 1'b0;
				else
					boost_needed = item.load_level > cfg.load_threshold;
			end
			default: boost_needed = 1'b0;
		endcase
		if (target != state.scene) begin
			state_next.scene   = target;
			state_next.elapsed = '0;
		end
	end

	assign result.scene         = state_next.scene;
	assign result.power_mode    = state_next.mode;
	assign result.scene_changed = (state_next.scene != state.scene);
	assign result.heavy_active  = state_next.heavy;
	assign result.boost_needed  = boost_needed;

endmodule

`default_nettype wire

// ===== hdl/power_scene_state_machine.sv =====
// Top level of the power scene state machine: input register, state, result register.
// Path: a word accepted into the input register passes through the step logic into the result
// register, and raises m_tvalid, once the result register is free.
// Throughput: one request word per cycle; the input register frees whenever the
// result register is empty or being read.
// Reset: arst_n clears the scene to idle, mode to MODE_RESET, counters and flags to zero,
// all hint timeouts and the threshold to zero and the boost slack to 3000 ms.
`timescale 1ns / 1ps
`default_nettype none

module power_scene_state_machine (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [23:0] s_tdata,   // event_code[3:0], new_mode[6:4], load_level[22:7], zero pad
	input  wire [1:0]  s_tuser,   // req_type[1:0]
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata,  // scene[2:0], power_mode[5:3], scene_changed[6],
	                              // heavy_active[7], boost_needed[8], zero pad
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [2:0]  cfg_index,
	input  wire [19:0] cfg_data
);
	import pssm_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_q;
	logic    advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{hint_touch_ms: '0, hint_trigger_ms: '0, hint_junk_ms: '0,
			           hint_gesture_ms: '0, hint_switch_ms: '0,
			           burst_slack_ms: SLACK_RESET, load_threshold: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HINT_TOUCH:   cfg_q.hint_touch_ms   <= cfg_data;
				CFG_HINT_TRIGGER: cfg_q.hint_trigger_ms <= cfg_data;
				CFG_HINT_JUNK:    cfg_q.hint_junk_ms    <= cfg_data;
				CFG_HINT_GESTURE: cfg_q.hint_gesture_ms <= cfg_data;
				CFG_HINT_SWITCH:  cfg_q.hint_switch_ms  <= cfg_data;
				CFG_BURST_SLACK:  cfg_q.burst_slack_ms  <= cfg_data[15:0];
				CFG_HEAVY_THRESH: cfg_q.load_threshold  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type   <= req_t'(s_tuser);
			item_s1.event_code <= s_tdata[3:0];
			item_s1.new_mode   <= s_tdata[6:4];
			item_s1.load_level <= s_tdata[22:7];
		end
	end

	pssm_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{scene: SC_IDLE, mode: MODE_RESET, elapsed: '0, heavy: 1'b0,
			             boost_exited: 1'b0, cooldown: '0};
			m_tvalid <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_next;
			if (advance)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result;
	end

	assign m_tdata = {7'd0, result_q};

	a_no_stall_without_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a held result");

	a_scene_change_clears_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_next.scene != state_q.scene |=> state_q.elapsed == '0)
		else $error("scene change did not clear elapsed time");

	a_query_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.req_type == REQ_QUERY |=> $stable(state_q))
		else $error("boost query altered state");

	a_boost_only_on_query: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.req_type != REQ_QUERY |=> !result_q.boost_needed)
		else $error("boost answer on a non-query word");

	a_mode_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> {1'b0, state_q.mode} < MODE_COUNT || state_q.mode == MODE_RESET)
		else $error("power mode out of range");

endmodule

`default_nettype wire
